// File: rtl/htfc_pkg.sv
// ============================================================================
// htfc_pkg
// Shared types, constants and helper functions for the humidity and
// temperature frame checker.
// ============================================================================
package htfc_pkg;

    // CRC-8 settings: polynomial x^8 + x^5 + x^4 + 1, no reflection, no final xor
    localparam logic [7:0] CRC_START = 8'hFF;
    localparam logic [7:0] CRC_POLY  = 8'h31;

    // Scaling to hundredths: span * raw / FULL_SCALE
    localparam logic [14:0] TEMP_SPAN_CENTI   = 15'd17500;
    localparam logic [14:0] TEMP_OFFSET_CENTI = 15'd4500;
    localparam logic [13:0] HUM_SPAN_CENTI    = 14'd10000;
    localparam logic [15:0] FULL_SCALE        = 16'hFFFF;

    // Widths of the scaled products
    localparam int TPROD_W = 31;
    localparam int HPROD_W = 30;

    // Checked words of one frame, handed from the frame sequencer to scaling
    typedef struct packed {
        logic        temp_ok;
        logic        hum_ok;
        logic [15:0] temp_word;
        logic [15:0] hum_word;
    } t_meas;

    // One byte through the CRC-8 shift register, MSB first
    function automatic logic [7:0] crc_feed(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

    // x / 65535 for x below 2^31: quotient estimate x >> 16, remainder
    // (x mod 2^16) + estimate stays below twice the divisor, so one
    // compare and increment settles it.
    function automatic logic [15:0] div_full_scale(input logic [TPROD_W-1:0] x);
        logic [14:0] q0;
        logic [16:0] rem;
        q0  = x[TPROD_W-1:16];
        rem = {1'b0, x[15:0]} + {2'b00, q0};
        if (rem >= {1'b0, FULL_SCALE}) begin
            return {1'b0, q0} + 16'd1;
        end else begin
            return {1'b0, q0};
        end
    endfunction

endpackage

// File: rtl/htfc_frame.sv
// ============================================================================
// htfc_frame
// Byte sequencer for the six-byte frame: tracks the byte position, runs the
// CRC-8 over each word and keeps the last good temperature and humidity.
// ============================================================================
module htfc_frame
    import htfc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [7:0]  i_data_byte,
    input  logic        i_frame_start,
    output logic        o_res_valid,
    output t_meas       o_res
);

    // Byte positions within a frame
    localparam logic [2:0] POS_T_HI  = 3'd0;
    localparam logic [2:0] POS_T_LO  = 3'd1;
    localparam logic [2:0] POS_T_CRC = 3'd2;
    localparam logic [2:0] POS_H_HI  = 3'd3;
    localparam logic [2:0] POS_H_LO  = 3'd4;
    localparam logic [2:0] POS_H_CRC = 3'd5;

    logic [2:0]  r_pos,       n_pos;
    logic [7:0]  r_crc,       n_crc;
    logic [7:0]  r_hi_byte,   n_hi_byte;
    logic [7:0]  r_lo_byte,   n_lo_byte;
    logic        r_temp_good, n_temp_good;
    logic [15:0] r_temp,      n_temp;
    logic [15:0] r_hum,       n_hum;

    logic [2:0]  pos;
    logic [7:0]  crc_in;
    logic [7:0]  crc_next;
    logic [15:0] word;
    logic        crc_match;
    logic        frame_done;

    // Position of this beat: a frame start mark or an unreachable code
    // restarts the frame
    always_comb begin
        if (i_frame_start || r_pos > POS_H_CRC) begin
            pos = POS_T_HI;
        end else begin
            pos = r_pos;
        end
    end

    assign crc_in    = (pos == POS_T_HI || pos == POS_H_HI) ? CRC_START : r_crc;
    assign crc_next  = crc_feed(crc_in, i_data_byte);
    assign word      = {r_hi_byte, r_lo_byte};
    assign crc_match = (i_data_byte == r_crc);

    // Next-state decode per position
    always_comb begin
        n_pos       = r_pos;
        n_crc       = r_crc;
        n_hi_byte   = r_hi_byte;
        n_lo_byte   = r_lo_byte;
        n_temp_good = r_temp_good;
        n_temp      = r_temp;
        n_hum       = r_hum;
        frame_done  = 1'b0;
        unique case (pos) inside
            POS_T_HI, POS_H_HI: begin
                if (pos == POS_T_HI) begin
                    n_temp_good = 1'b0;
                end
                n_hi_byte = i_data_byte;
                n_crc     = crc_next;
                n_pos     = pos + 3'd1;
            end
            POS_T_LO, POS_H_LO: begin
                n_lo_byte = i_data_byte;
                n_crc     = crc_next;
                n_pos     = pos + 3'd1;
            end
            POS_T_CRC: begin
                n_temp_good = crc_match;
                if (crc_match) begin
                    n_temp = word;
                end
                n_crc = CRC_START;
                n_pos = POS_H_HI;
            end
            default: begin
                // humidity CRC byte closes the frame
                if (crc_match) begin
                    n_hum = word;
                end
                n_crc      = CRC_START;
                n_pos      = POS_T_HI;
                frame_done = 1'b1;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= POS_T_HI;
            r_crc       <= CRC_START;
            r_temp_good <= 1'b0;
            r_temp      <= '0;
            r_hum       <= '0;
        end else if (i_accept) begin
            r_pos       <= n_pos;
            r_crc       <= n_crc;
            r_temp_good <= n_temp_good;
            r_temp      <= n_temp;
            r_hum       <= n_hum;
        end
    end

    // Word holding bytes, always written before read
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_hi_byte <= n_hi_byte;
            r_lo_byte <= n_lo_byte;
        end
    end

    // Result of a completed frame
    assign o_res_valid     = i_accept && frame_done;
    assign o_res.temp_ok   = r_temp_good;
    assign o_res.hum_ok    = crc_match;
    assign o_res.temp_word = r_temp;
    assign o_res.hum_word  = n_hum;

endmodule

// File: rtl/htfc_scale.sv
// ============================================================================
// htfc_scale
// Three-stage pipeline that turns the checked raw words into hundredths:
// capture, constant multiply, divide by full scale and offset.
// ============================================================================
module htfc_scale
    import htfc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  t_meas              i_in,
    output logic               o_in_ready,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_valid_count,
    output logic               o_temperature_ok,
    output logic               o_humidity_ok,
    output logic [15:0]        o_temperature_word,
    output logic [15:0]        o_humidity_word,
    output logic signed [14:0] o_temperature_centi,
    output logic [13:0]        o_humidity_centi
);

    logic               r_v1, r_v2, r_v3;
    t_meas              r_m1, r_m2;
    logic [TPROD_W-1:0] r_tprod;
    logic [HPROD_W-1:0] r_hprod;
    logic               rdy1, rdy2, rdy3;
    logic [15:0]        t_quot;
    logic [15:0]        h_quot;

    // Each stage moves on when it is empty or the next one moves
    assign rdy3       = !r_v3 || !i_stall;
    assign rdy2       = !r_v2 || rdy3;
    assign rdy1       = !r_v1 || rdy2;
    assign o_in_ready = rdy1;

    // Valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (rdy1) begin
                r_v1 <= i_in_valid;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
        end
    end

    // Stage 1: capture the frame result
    always_ff @(posedge i_clk) begin
        if (rdy1 && i_in_valid) begin
            r_m1 <= i_in;
        end
    end

    // Stage 2: scale by the span
    always_ff @(posedge i_clk) begin
        if (rdy2 && r_v1) begin
            r_m2    <= r_m1;
            r_tprod <= TPROD_W'({16'd0, TEMP_SPAN_CENTI} * {15'd0, r_m1.temp_word});
            r_hprod <= HPROD_W'({16'd0, HUM_SPAN_CENTI} * {14'd0, r_m1.hum_word});
        end
    end

    // Stage 3: divide by full scale, remove the temperature offset
    assign t_quot = div_full_scale(r_tprod);
    assign h_quot = div_full_scale({{(TPROD_W-HPROD_W){1'b0}}, r_hprod});

    always_ff @(posedge i_clk) begin
        if (rdy3 && r_v2) begin
            o_valid_count       <= {1'b0, r_m2.temp_ok} + {1'b0, r_m2.hum_ok};
            o_temperature_ok    <= r_m2.temp_ok;
            o_humidity_ok       <= r_m2.hum_ok;
            o_temperature_word  <= r_m2.temp_word;
            o_humidity_word     <= r_m2.hum_word;
            o_temperature_centi <= $signed(t_quot[14:0] - TEMP_OFFSET_CENTI);
            o_humidity_centi    <= h_quot[13:0];
        end
    end

    assign o_valid = r_v3;

endmodule

// File: rtl/humidity_temp_frame_checker.sv
// ============================================================================
// humidity_temp_frame_checker
// CRC-8 check and unit conversion of a six-byte humidity/temperature frame.
// ============================================================================
// Bytes arrive one per beat in the order temperature MSB, LSB, CRC, humidity
// MSB, LSB, CRC; i_frame_start marks a byte as the first of a frame and drops
// any partial frame. One byte is taken every clock cycle while o_stall is low.
// Each word is checked with CRC-8 (poly 0x31, start 0xFF); a good word
// replaces the stored one, a bad word leaves it alone. Every sixth byte yields
// one result beat via the stage registers, carrying the good-word count, both
// stored raw words and their values in hundredths of a degree and of a
// percent. The scaling pipeline is three registers deep and holds up to three
// results; o_stall rises only once all three are held against i_stall.
module humidity_temp_frame_checker
    import htfc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [7:0]         i_data_byte,
    input  logic               i_frame_start,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_valid_count,
    output logic               o_temperature_ok,
    output logic               o_humidity_ok,
    output logic [15:0]        o_temperature_word,
    output logic [15:0]        o_humidity_word,
    output logic signed [14:0] o_temperature_centi,
    output logic [13:0]        o_humidity_centi
);

    logic  in_ready;
    logic  accept;
    logic  res_valid;
    t_meas res;

    assign o_stall = !in_ready;
    assign accept  = i_valid && in_ready;

    // Frame sequencing and CRC
    htfc_frame u_frame (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_data_byte   (i_data_byte),
        .i_frame_start (i_frame_start),
        .o_res_valid   (res_valid),
        .o_res         (res)
    );

    // Conversion pipeline and output register
    htfc_scale u_scale (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (res_valid),
        .i_in                (res),
        .o_in_ready          (in_ready),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_valid_count       (o_valid_count),
        .o_temperature_ok    (o_temperature_ok),
        .o_humidity_ok       (o_humidity_ok),
        .o_temperature_word  (o_temperature_word),
        .o_humidity_word     (o_humidity_word),
        .o_temperature_centi (o_temperature_centi),
        .o_humidity_centi    (o_humidity_centi)
    );

endmodule

// File: rtl/htfc_checker.sv
// ============================================================================
// htfc_checker
// Port-level checks on the frame checker's result beats, bound to the top.
// ============================================================================
module htfc_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               o_stall,
    input  logic               o_valid,
    input  logic               i_stall,
    input  logic [1:0]         o_valid_count,
    input  logic               o_temperature_ok,
    input  logic               o_humidity_ok,
    input  logic [15:0]        o_temperature_word,
    input  logic [15:0]        o_humidity_word,
    input  logic signed [14:0] o_temperature_centi,
    input  logic [13:0]        o_humidity_centi
);

    // Count agrees with the two flags
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ({1'b0, o_temperature_ok} + {1'b0, o_humidity_ok} == o_valid_count))
        else $error("valid_count does not match the ok flags");

    // Converted values stay within the sensor range
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_humidity_centi <= 14'd10000 && o_temperature_centi >= -15'sd4500
                     && o_temperature_centi <= 15'sd13000))
        else $error("converted value out of range");

    // A stalled result beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_temperature_word)
                               && $stable(o_humidity_word)
                               && $stable(o_humidity_centi))
        else $error("stalled result beat changed");

    // Input is held off only while a result beat waits on the receiver
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled with no result beat held");

    // Reset empties the pipeline
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result beat straight after reset");

endmodule

bind humidity_temp_frame_checker htfc_checker u_htfc_checker (.*);
